// ===== hw/rtl/sqg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqg_pkg
// Shared types and constants for the single-qubit gate apply block.
// ----------------------------------------------------------------------------
package sqg_pkg;

  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned AMP_W    = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned QCNT_W   = 4;
  localparam int unsigned CFG_AW   = 5;
  localparam int unsigned CFG_DW   = 32;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_QUBIT_COUNT  = 3'd0;
  localparam logic [2:0] REG_TARGET_QUBIT = 3'd1;
  localparam logic [2:0] REG_COEF_00      = 3'd2;
  localparam logic [2:0] REG_COEF_01      = 3'd3;
  localparam logic [2:0] REG_COEF_10      = 3'd4;
  localparam logic [2:0] REG_COEF_11      = 3'd5;

  // Reset values: Hadamard-like gate, +-11585 is 1/sqrt(2) in Q1.14.
  localparam logic [QCNT_W-1:0] RST_QUBIT_COUNT  = 4'd10;
  localparam logic [QCNT_W-1:0] RST_TARGET_QUBIT = 4'd1;
  localparam logic [WORD_W-1:0] RST_COEF_POS     = 32'h2D41_0000;
  localparam logic [WORD_W-1:0] RST_COEF_NEG     = 32'hD2BF_0000;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_READ  = 1'b1;

  typedef struct packed {
    logic [QCNT_W-1:0] qubit_count;
    logic [QCNT_W-1:0] target_qubit;
    logic [WORD_W-1:0] coef_00;
    logic [WORD_W-1:0] coef_01;
    logic [WORD_W-1:0] coef_10;
    logic [WORD_W-1:0] coef_11;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic mem_we;     // store the accepted write transaction
    logic rd_lo;      // read lower partner for the accepted read transaction
    logic rd_hi;      // read upper partner from the captured index
    logic mul_lo;     // multiply lower partner by the first coefficient
    logic mul_hi;     // multiply upper partner by the second coefficient
    logic load_out;   // sum, round, saturate into the output register
  } dp_cmd_t;

endpackage

// ===== hw/rtl/sqg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqg_in_if / sqg_out_if
// Valid/ready channels for amplitude transactions and gated results.
// ----------------------------------------------------------------------------
interface sqg_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [sqg_pkg::INDEX_W-1:0]       index;
  logic signed [sqg_pkg::AMP_W-1:0]  amp_re;
  logic signed [sqg_pkg::AMP_W-1:0]  amp_im;

  modport source (output valid, action, index, amp_re, amp_im, input ready);
  modport sink   (input valid, action, index, amp_re, amp_im, output ready);
endinterface

interface sqg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sqg_pkg::AMP_W-1:0]  result_re;
  logic signed [sqg_pkg::AMP_W-1:0]  result_im;

  modport source (output valid, result_re, result_im, input ready);
  modport sink   (input valid, result_re, result_im, output ready);
endinterface

// ===== hw/rtl/sqg_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqg_cfg_regs
// APB-style register file holding qubit count, target qubit and gate entries.
// ----------------------------------------------------------------------------
module sqg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqg_pkg::CFG_AW-1:0]    paddr,
  input  logic [sqg_pkg::CFG_DW-1:0]    pwdata,
  output logic [sqg_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output sqg_pkg::cfg_t                 cfg
);

  sqg_pkg::cfg_t cfg_r;
  sqg_pkg::cfg_t cfg_nxt;
  logic [2:0]    reg_sel;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[sqg_pkg::CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        sqg_pkg::REG_QUBIT_COUNT:  cfg_nxt.qubit_count  = pwdata[sqg_pkg::QCNT_W-1:0];
        sqg_pkg::REG_TARGET_QUBIT: cfg_nxt.target_qubit = pwdata[sqg_pkg::QCNT_W-1:0];
        sqg_pkg::REG_COEF_00:      cfg_nxt.coef_00      = pwdata;
        sqg_pkg::REG_COEF_01:      cfg_nxt.coef_01      = pwdata;
        sqg_pkg::REG_COEF_10:      cfg_nxt.coef_10      = pwdata;
        sqg_pkg::REG_COEF_11:      cfg_nxt.coef_11      = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.qubit_count  <= sqg_pkg::RST_QUBIT_COUNT;
      cfg_r.target_qubit <= sqg_pkg::RST_TARGET_QUBIT;
      cfg_r.coef_00      <= sqg_pkg::RST_COEF_POS;
      cfg_r.coef_01      <= sqg_pkg::RST_COEF_POS;
      cfg_r.coef_10      <= sqg_pkg::RST_COEF_POS;
      cfg_r.coef_11      <= sqg_pkg::RST_COEF_NEG;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      sqg_pkg::REG_QUBIT_COUNT:  prdata = {28'd0, cfg_r.qubit_count};
      sqg_pkg::REG_TARGET_QUBIT: prdata = {28'd0, cfg_r.target_qubit};
      sqg_pkg::REG_COEF_00:      prdata = cfg_r.coef_00;
      sqg_pkg::REG_COEF_01:      prdata = cfg_r.coef_01;
      sqg_pkg::REG_COEF_10:      prdata = cfg_r.coef_10;
      sqg_pkg::REG_COEF_11:      prdata = cfg_r.coef_11;
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/sqg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqg_ctrl
// Sequencer for store writes and the four-step gated read.
// ----------------------------------------------------------------------------
module sqg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sqg_pkg::dp_cmd_t  cmd
);

  sqg_pkg::state_t state_r;
  sqg_pkg::state_t state_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            in_acc;
  logic            out_free;

  assign in_ready  = (state_r == sqg_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sqg_pkg::ST_IDLE: begin
        if (in_acc && in_action == sqg_pkg::ACTION_READ) state_nxt = sqg_pkg::ST_LO;
      end
      sqg_pkg::ST_LO:  state_nxt = sqg_pkg::ST_HI;
      sqg_pkg::ST_HI:  state_nxt = sqg_pkg::ST_SUM;
      sqg_pkg::ST_SUM: begin
        if (out_free) state_nxt = sqg_pkg::ST_IDLE;
      end
      default: state_nxt = sqg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      sqg_pkg::ST_IDLE: begin
        cmd.mem_we = in_acc && in_action == sqg_pkg::ACTION_WRITE;
        cmd.rd_lo  = in_acc && in_action == sqg_pkg::ACTION_READ;
      end
      sqg_pkg::ST_LO: begin
        cmd.rd_hi  = 1'b1;
        cmd.mul_lo = 1'b1;
      end
      sqg_pkg::ST_HI:  cmd.mul_hi   = 1'b1;
      sqg_pkg::ST_SUM: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/sqg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqg_datapath
// Amplitude store, partner addressing, complex multiply and round/saturate.
// ----------------------------------------------------------------------------
module sqg_datapath #(
  parameter int unsigned MAX_QUBITS = 10
) (
  input  logic                               clk,
  input  sqg_pkg::cfg_t                      cfg,
  input  sqg_pkg::dp_cmd_t                   cmd,
  input  logic [sqg_pkg::INDEX_W-1:0]        in_index,
  input  logic signed [sqg_pkg::AMP_W-1:0]   in_amp_re,
  input  logic signed [sqg_pkg::AMP_W-1:0]   in_amp_im,
  output logic signed [sqg_pkg::AMP_W-1:0]   result_re,
  output logic signed [sqg_pkg::AMP_W-1:0]   result_im
);

  localparam int unsigned AW    = MAX_QUBITS;
  localparam int unsigned DEPTH = 1 << MAX_QUBITS;

  logic [sqg_pkg::WORD_W-1:0] mem [DEPTH];
  logic [sqg_pkg::WORD_W-1:0] mem_q_r;
  logic [AW-1:0]              mem_addr;
  logic [AW-1:0]              in_idx;
  logic [AW-1:0]              idx_r;
  logic [AW-1:0]              l_mask;
  logic [sqg_pkg::QCNT_W-1:0] bit_pos;
  logic                       row_hi;
  logic [sqg_pkg::WORD_W-1:0] coef_sel;

  logic signed [15:0] c_re, c_im, a_re, a_im;
  logic signed [31:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [32:0] p_re, p_im;
  logic signed [32:0] lo_re_r, lo_im_r, hi_re_r, hi_im_r;
  logic signed [34:0] sum_re, sum_im, q_re, q_im;
  logic signed [15:0] sat_re, sat_im;
  logic signed [15:0] result_re_r, result_im_r;

  assign in_idx = AW'(in_index);

  // Partner bit: qubit_count - target_qubit, only when the target is in range.
  always_comb begin
    l_mask  = '0;
    bit_pos = cfg.qubit_count - cfg.target_qubit;
    if (cfg.target_qubit != '0 && cfg.target_qubit <= cfg.qubit_count
        && 32'(bit_pos) < MAX_QUBITS) begin
      l_mask = AW'(1) << bit_pos;
    end
  end

  always_comb begin
    if (cmd.rd_hi) begin
      mem_addr = idx_r | l_mask;
    end else if (cmd.mem_we) begin
      mem_addr = in_idx;
    end else begin
      mem_addr = in_idx & ~l_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[mem_addr] <= {in_amp_re, in_amp_im};
    end else begin
      mem_q_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_lo) begin
      idx_r <= in_idx;
    end
  end

  // The row of the gate follows the partner bit of the read index.
  assign row_hi = |(idx_r & l_mask);

  always_comb begin
    if (cmd.mul_lo) begin
      coef_sel = row_hi ? cfg.coef_10 : cfg.coef_00;
    end else begin
      coef_sel = row_hi ? cfg.coef_11 : cfg.coef_01;
    end
    c_re = $signed(coef_sel[31:16]);
    c_im = $signed(coef_sel[15:0]);
    a_re = $signed(mem_q_r[31:16]);
    a_im = $signed(mem_q_r[15:0]);
    m_rr = c_re * a_re;
    m_ii = c_im * a_im;
    m_ri = c_re * a_im;
    m_ir = c_im * a_re;
    p_re = 33'(m_rr) - 33'(m_ii);
    p_im = 33'(m_ri) + 33'(m_ir);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      lo_re_r <= p_re;
      lo_im_r <= p_im;
    end
    if (cmd.mul_hi) begin
      hi_re_r <= p_re;
      hi_im_r <= p_im;
    end
  end

  // Round half up to Q1.14, then clamp to the 16-bit range.
  always_comb begin
    sum_re = 35'(lo_re_r) + 35'(hi_re_r) + 35'sd8192;
    sum_im = 35'(lo_im_r) + 35'(hi_im_r) + 35'sd8192;
    q_re   = sum_re >>> 14;
    q_im   = sum_im >>> 14;
    if (q_re > 35'sd32767) begin
      sat_re = 16'sh7FFF;
    end else if (q_re < -35'sd32768) begin
      sat_re = -16'sh8000;
    end else begin
      sat_re = q_re[15:0];
    end
    if (q_im > 35'sd32767) begin
      sat_im = 16'sh7FFF;
    end else if (q_im < -35'sd32768) begin
      sat_im = -16'sh8000;
    end else begin
      sat_im = q_im[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_re_r <= sat_re;
      result_im_r <= sat_im;
    end
  end

  assign result_re = result_re_r;
  assign result_im = result_im_r;

endmodule

// ===== hw/rtl/single_qubit_gate_apply_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_qubit_gate_apply_top
// Applies a 2x2 complex Q1.14 gate to one qubit of a stored state vector.
// ----------------------------------------------------------------------------
// Usage: a transaction on in_ch with action = write stores {amp_re, amp_im}
// at index and produces no result. A transaction with action = read returns
// on out_ch the gated amplitude at index, built from the stored entry and
// its partner across the target qubit, rounded half up and saturated.
// Configuration (qubit count, target qubit, four gate entries) must be written
// through the APB-style port while the block is idle; the block does not enforce it.
// Operation: a write is stored as it is accepted. A read is accepted, then the
// single-port amplitude memory is read twice (lower and upper partner) with
// each partner multiplied by its gate entry in the following cycle, and the
// sum is rounded into the output register, which presents the result; a new
// transaction is taken only once the sequencer is back in idle. A waiting
// result does not block intake; only a second read holds in its final step
// while out_ch stalls.
// Reset loads the default gate and qubit settings and clears the output
// valid; the amplitude memory is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module single_qubit_gate_apply_top #(
  parameter int unsigned MAX_QUBITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sqg_in_if.sink                        in_ch,
  sqg_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqg_pkg::CFG_AW-1:0]    paddr,
  input  logic [sqg_pkg::CFG_DW-1:0]    pwdata,
  output logic [sqg_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  sqg_pkg::cfg_t    cfg;
  sqg_pkg::dp_cmd_t cmd;

  sqg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sqg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sqg_datapath #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_dp (
    .clk       (clk),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_index  (in_ch.index),
    .in_amp_re (in_ch.amp_re),
    .in_amp_im (in_ch.amp_im),
    .result_re (out_ch.result_re),
    .result_im (out_ch.result_im)
  );

endmodule
